[sv/vnf_pkg.sv]
// Package for the fractal value noise block.
// Holds the hash and mixer constants, the configuration register codes
// and the pipeline sizes that the lane and the top level share.
package vnf_pkg;

  localparam int unsigned MAX_OCTAVES_DEF = 4;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned NOISE_W = 24;
  localparam int unsigned WGT_W   = 16;
  localparam int unsigned SEED_W  = 32;
  localparam int unsigned OCT_W   = 3;

  localparam logic [31:0] MIX_MUL_A     = 32'h7feb352d;
  localparam logic [31:0] MIX_MUL_B     = 32'h846ca68b;
  localparam logic [31:0] PRIME_X       = 32'd73856093;
  localparam logic [31:0] PRIME_Y       = 32'd19349663;
  localparam int unsigned OCT_SEED_STEP = 101;

  // Stages inside one octave lane, and stages of the whole pipeline
  // (input register, lane stages, output register).
  localparam int unsigned LANE_STAGES = 7;
  localparam int unsigned PIPE_STAGES = LANE_STAGES + 2;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NOISE_SEED   = 2'd0,
    CFG_OCTAVE_COUNT = 2'd1
  } cfg_reg_e;

  typedef logic [LANE_STAGES-1:0] lane_en_t;

endpackage

[sv/vnf_hash.sv]
// Three-stage integer mixer for one lattice corner of the noise.
// Takes the pre-mixed hash and returns the low 24 bits of the mixed word.
// Depends on vnf_pkg for the mixer constants.
module vnf_hash (
  input  logic                         clk_i,
  input  logic [2:0]                   en_i,
  input  logic [31:0]                  hash_i,
  output logic [vnf_pkg::NOISE_W-1:0]  value_o
);
  import vnf_pkg::*;

  logic [31:0]        mul_a_q;
  logic [31:0]        mul_b_q;
  logic [31:0]        mix_a;
  logic [31:0]        mix_b;
  logic [NOISE_W-1:0] value_q;

  assign mix_a = mul_a_q ^ (mul_a_q >> 15);
  assign mix_b = mul_b_q ^ (mul_b_q >> 16);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      mul_a_q <= 32'(hash_i * MIX_MUL_A);
    end
    if (en_i[1]) begin
      mul_b_q <= 32'(mix_a * MIX_MUL_B);
    end
    if (en_i[2]) begin
      value_q <= mix_b[NOISE_W-1:0];
    end
  end

  assign value_o = value_q;

endmodule

[sv/vnf_lane.sv]
// One octave lane of the noise pipeline: lattice split, smoothstep weights,
// four corner hashes and the bilinear blend, over seven register stages.
// Depends on vnf_pkg and instantiates vnf_hash once per corner.
module vnf_lane #(
  parameter int unsigned OCT = 0
) (
  input  logic                               clk_i,
  input  vnf_pkg::lane_en_t                  en_i,
  input  logic [vnf_pkg::SEED_W-1:0]         seed_i,
  input  logic signed [vnf_pkg::COORD_W-1:0] coord_x_i,
  input  logic signed [vnf_pkg::COORD_W-1:0] coord_y_i,
  output logic [vnf_pkg::NOISE_W-1:0]        value_o
);
  import vnf_pkg::*;

  localparam int unsigned SCW = 48;
  localparam logic [SEED_W-1:0] SeedOfs = SEED_W'(OCT_SEED_STEP * OCT);
  localparam logic [17:0] ThreeOne = 18'd196608;

  function automatic logic [NOISE_W-1:0] lerp24(input logic [NOISE_W-1:0] lo,
                                                input logic [NOISE_W-1:0] hi,
                                                input logic [WGT_W-1:0] w);
    logic signed [24:0] diff;
    logic signed [41:0] prod;
    logic signed [41:0] sum;
    diff = $signed({1'b0, hi}) - $signed({1'b0, lo});
    prod = 42'(diff) * 42'($signed({1'b0, w}));
    sum  = $signed({2'b00, lo, 16'h0000}) + prod;
    return sum[39:16];
  endfunction

  logic signed [SCW-1:0] scl_x;
  logic signed [SCW-1:0] scl_y;
  logic [31:0]           cell_x;
  logic [31:0]           cell_y;
  logic [WGT_W-1:0]      frac_x;
  logic [WGT_W-1:0]      frac_y;

  logic [WGT_W-1:0] fx_q;
  logic [WGT_W-1:0] fy_q;
  logic [31:0]      ffx_q;
  logic [31:0]      ffy_q;
  logic [31:0]      px_q;
  logic [31:0]      py_q;

  logic [17:0]      tx;
  logic [17:0]      ty;
  logic [49:0]      prod_x;
  logic [49:0]      prod_y;
  logic [31:0]      px1;
  logic [31:0]      py1;
  logic [31:0]      seed_lane;
  logic [31:0]      hash_raw [4];
  logic [31:0]      hash_q [4];
  logic [WGT_W-1:0] wx_q [4];
  logic [WGT_W-1:0] wy_q [5];

  logic [NOISE_W-1:0] corner [4];
  logic [NOISE_W-1:0] top_q;
  logic [NOISE_W-1:0] bot_q;
  logic [NOISE_W-1:0] value_q;

  assign scl_x  = SCW'(coord_x_i) <<< OCT;
  assign scl_y  = SCW'(coord_y_i) <<< OCT;
  assign cell_x = scl_x[47:16];
  assign cell_y = scl_y[47:16];
  assign frac_x = scl_x[15:0];
  assign frac_y = scl_y[15:0];

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      fx_q  <= frac_x;
      fy_q  <= frac_y;
      ffx_q <= 32'(frac_x) * 32'(frac_x);
      ffy_q <= 32'(frac_y) * 32'(frac_y);
      px_q  <= 32'(cell_x * PRIME_X);
      py_q  <= 32'(cell_y * PRIME_Y);
    end
  end

  assign tx        = ThreeOne - {1'b0, fx_q, 1'b0};
  assign ty        = ThreeOne - {1'b0, fy_q, 1'b0};
  assign prod_x    = 50'(ffx_q) * 50'(tx);
  assign prod_y    = 50'(ffy_q) * 50'(ty);
  assign px1       = px_q + PRIME_X;
  assign py1       = py_q + PRIME_Y;
  assign seed_lane = seed_i + SeedOfs;

  assign hash_raw[0] = px_q ^ py_q ^ seed_lane;
  assign hash_raw[1] = px1 ^ py_q ^ seed_lane;
  assign hash_raw[2] = px_q ^ py1 ^ seed_lane;
  assign hash_raw[3] = px1 ^ py1 ^ seed_lane;

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      wx_q[0] <= prod_x[47:32];
      wy_q[0] <= prod_y[47:32];
      for (int k = 0; k < 4; k++) begin
        hash_q[k] <= hash_raw[k] ^ (hash_raw[k] >> 16);
      end
    end
    for (int k = 1; k < 4; k++) begin
      if (en_i[k+1]) begin
        wx_q[k] <= wx_q[k-1];
      end
    end
    for (int k = 1; k < 5; k++) begin
      if (en_i[k+1]) begin
        wy_q[k] <= wy_q[k-1];
      end
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_corner
    vnf_hash u_hash (
      .clk_i   (clk_i),
      .en_i    (en_i[4:2]),
      .hash_i  (hash_q[g]),
      .value_o (corner[g])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en_i[5]) begin
      top_q <= lerp24(corner[0], corner[1], wx_q[3]);
      bot_q <= lerp24(corner[2], corner[3], wx_q[3]);
    end
    if (en_i[6]) begin
      value_q <= lerp24(top_q, bot_q, wy_q[4]);
    end
  end

  assign value_o = value_q;

endmodule

[sv/value_noise_fbm_2d.sv]
// Top level of the fractal 2-D value noise block.
// Holds the configuration registers, the pipeline valid bits and flow
// control, one vnf_lane per octave and the octave sum. Depends on vnf_pkg.
//
// Each input beat carries a sample point (coord_x, coord_y) in signed Q16.16
// and gives exactly one output beat, noise_value in unsigned Q0.24. A beat
// moves on a channel at a clock edge where valid is high and stall is low.
// The pipeline has nine register stages: the input register, seven lane
// stages and the output register. While the receiver does not stall, a new
// beat is taken every cycle, so throughput is one sample per clock; the
// registered 32-bit multipliers of the corner mixer and the blend
// multipliers set the stage depth. Octaves run in parallel lanes, one lane
// per octave up to MAX_OCTAVES.
// When the receiver stalls, every stage that holds a beat keeps it, empty
// stages further up still fill, and in_stall_o rises only when the stages
// up to the input are all full. Reset empties the pipeline, sets noise_seed
// to 0 and octave_count to 4. Configuration writes are always taken and
// are meant to happen while no beat is in flight.
module value_noise_fbm_2d #(
  parameter int unsigned MAX_OCTAVES = vnf_pkg::MAX_OCTAVES_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [vnf_pkg::COORD_W-1:0]   coord_x_i,
  input  logic signed [vnf_pkg::COORD_W-1:0]   coord_y_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [vnf_pkg::NOISE_W-1:0]          noise_value_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [vnf_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [vnf_pkg::CFG_DATA_W-1:0]       cfg_data_i
);
  import vnf_pkg::*;

  logic [SEED_W-1:0] seed_q;
  logic [OCT_W-1:0]  oct_q;
  logic [3:0]        oct_eff;

  logic [PIPE_STAGES-1:0] vld_q;
  logic [PIPE_STAGES-1:0] rdy;

  logic signed [COORD_W-1:0] x_q;
  logic signed [COORD_W-1:0] y_q;
  logic [NOISE_W-1:0]        lane_val [MAX_OCTAVES];
  logic [NOISE_W-1:0]        sum;
  logic [NOISE_W-1:0]        noise_q;
  lane_en_t                  lane_en;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
      oct_q  <= OCT_W'(4);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_NOISE_SEED:   seed_q <= cfg_data_i[SEED_W-1:0];
        CFG_OCTAVE_COUNT: oct_q  <= cfg_data_i[OCT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    priority if (oct_q == '0) begin
      oct_eff = 4'd1;
    end else if (4'(oct_q) > 4'(MAX_OCTAVES)) begin
      oct_eff = 4'(MAX_OCTAVES);
    end else begin
      oct_eff = 4'(oct_q);
    end
  end

  // A stage can load when it is empty or its content moves on.
  always_comb begin
    rdy[PIPE_STAGES-1] = !vld_q[PIPE_STAGES-1] || !out_stall_i;
    for (int k = PIPE_STAGES - 2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < PIPE_STAGES; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  assign in_stall_o = !rdy[0];
  assign lane_en    = rdy[PIPE_STAGES-2:1];

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      x_q <= coord_x_i;
      y_q <= coord_y_i;
    end
  end

  for (genvar g = 0; g < MAX_OCTAVES; g++) begin : g_lane
    vnf_lane #(
      .OCT (g)
    ) u_lane (
      .clk_i     (clk_i),
      .en_i      (lane_en),
      .seed_i    (seed_q),
      .coord_x_i (x_q),
      .coord_y_i (y_q),
      .value_o   (lane_val[g])
    );
  end

  always_comb begin
    sum = '0;
    for (int i = 0; i < MAX_OCTAVES; i++) begin
      if (4'(i) < oct_eff) begin
        sum = sum + (lane_val[i] >> (i + 1));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[PIPE_STAGES-1]) begin
      noise_q <= sum;
    end
  end

  assign out_valid_o   = vld_q[PIPE_STAGES-1];
  assign noise_value_o = noise_q;

`ifndef SYNTHESIS
  a_accept_fills_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> vld_q[0])
    else $error("Accepted input beat did not enter the first stage.");

  a_no_stall_when_draining: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("Input stalled while the output side drains.");

  a_full_and_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((&vld_q) && out_stall_i) |-> in_stall_o)
    else $error("Input taken while every stage is full and stalled.");

  a_output_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !vld_q[PIPE_STAGES-2]) |=> !out_valid_o)
    else $error("Output beat repeated after it was taken.");
`endif

endmodule
